[hw/rtl/brf_pkg.sv]
// Shared constants, command codes and controller interface types for the byte ring FIFO.
`default_nettype none

package brf_pkg;

   localparam int DEPTH_DEFAULT = 4096;
   localparam int CNT_W         = 13;
   localparam int CAP_RESET     = 4096;
   localparam int BYTE_W        = 8;
   localparam int TOTAL_W       = 64;

   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLOSE = 2'd2;
   localparam logic [1:0] CMD_ERROR = 2'd3;

   typedef struct packed {
      logic capture;
      logic exec;
      logic read;
      logic load;
      logic cfg_write;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } ctrl_sts_type;

endpackage

`default_nettype wire

[hw/rtl/brf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/brf_ctrl.sv]
// Controller state machine that sequences capture, update, head read and response load.
`default_nettype none

module brf_ctrl
   import brf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire ctrl_sts_type sts,
   output ctrl_cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_LOAD = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.cfg_write = csr_valid && (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!sts.out_blocked) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

[hw/rtl/brf_datapath.sv]
// Datapath holding ring pointers, counters, flags, the byte store and the response register.
`default_nettype none

module brf_datapath
   import brf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctrl_cmd_type       cmd,
   output ctrl_sts_type            sts,
   input  wire logic [1:0]         req_command,
   input  wire logic [BYTE_W-1:0]  req_byte_in,
   input  wire logic [CNT_W-1:0]   req_pop_count,
   input  wire logic [CNT_W-1:0]   csr_capacity,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_accepted,
   output logic      [BYTE_W-1:0]  rsp_head_byte,
   output logic                    rsp_head_valid,
   output logic      [CNT_W-1:0]   rsp_buffered,
   output logic      [CNT_W-1:0]   rsp_free_space,
   output logic      [TOTAL_W-1:0] rsp_pushed_total,
   output logic      [TOTAL_W-1:0] rsp_popped_total,
   output logic                    rsp_closed_flag,
   output logic                    rsp_error_flag,
   output logic                    rsp_finished
);

   localparam int AW      = $clog2(DEPTH);
   localparam int PW      = ((AW > CNT_W) ? AW : CNT_W) + 1;
   localparam int CAP_MAX = (DEPTH < (2**CNT_W - 1)) ? DEPTH : (2**CNT_W - 1);
   localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

   logic [1:0]         command_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic [CNT_W-1:0]   count_ff;

   logic [AW-1:0]      head_ff;
   logic [AW-1:0]      head_in;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_in;
   logic [CNT_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   cap_in;
   logic [TOTAL_W-1:0] push_ff;
   logic [TOTAL_W-1:0] push_in;
   logic [TOTAL_W-1:0] pop_ff;
   logic [TOTAL_W-1:0] pop_in;
   logic               closed_ff;
   logic               closed_in;
   logic               error_ff;
   logic               error_in;
   logic               accepted_ff;
   logic               accepted_in;
   logic               rsp_valid_ff;

   logic [CNT_W-1:0]   pop_n;
   logic [PW-1:0]      pop_sum;
   logic [PW-1:0]      pop_head;
   logic [PW-1:0]      tail_sum;
   logic [PW-1:0]      tail_pos;
   logic               can_push;
   logic               ram_we;
   logic [BYTE_W-1:0]  ram_rdata;

   logic               out_accepted_ff;
   logic [BYTE_W-1:0]  out_head_byte_ff;
   logic               out_head_valid_ff;
   logic [CNT_W-1:0]   out_buffered_ff;
   logic [CNT_W-1:0]   out_free_ff;
   logic [TOTAL_W-1:0] out_pushed_ff;
   logic [TOTAL_W-1:0] out_popped_ff;
   logic               out_closed_ff;
   logic               out_error_ff;
   logic               out_finished_ff;

   always_comb begin
      if (csr_capacity == '0) begin
         cap_in = CNT_W'(1);
      end else if (csr_capacity > CNT_W'(CAP_MAX)) begin
         cap_in = CNT_W'(CAP_MAX);
      end else begin
         cap_in = csr_capacity;
      end
   end

   always_comb begin
      pop_n    = (count_ff < fill_ff) ? count_ff : fill_ff;
      pop_sum  = PW'(head_ff) + PW'(pop_n);
      pop_head = (pop_sum >= PW'(cap_ff)) ? (pop_sum - PW'(cap_ff)) : pop_sum;
      tail_sum = PW'(head_ff) + PW'(fill_ff);
      tail_pos = (tail_sum >= PW'(cap_ff)) ? (tail_sum - PW'(cap_ff)) : tail_sum;
      can_push = !closed_ff && !error_ff && (fill_ff < cap_ff);
   end

   always_comb begin
      head_in     = head_ff;
      fill_in     = fill_ff;
      push_in     = push_ff;
      pop_in      = pop_ff;
      closed_in   = closed_ff;
      error_in    = error_ff;
      accepted_in = 1'b0;
      ram_we      = 1'b0;
      unique case (command_ff)
         CMD_PUSH: begin
            if (can_push) begin
               fill_in     = fill_ff + CNT_W'(1);
               push_in     = push_ff + TOTAL_W'(1);
               accepted_in = 1'b1;
               ram_we      = cmd.exec;
            end
         end
         CMD_POP: begin
            head_in = pop_head[AW-1:0];
            fill_in = fill_ff - pop_n;
            pop_in  = pop_ff + TOTAL_W'(pop_n);
         end
         CMD_CLOSE: begin
            closed_in = 1'b1;
         end
         CMD_ERROR: begin
            error_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff <= req_command;
         byte_ff    <= req_byte_in;
         count_ff   <= req_pop_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         fill_ff     <= '0;
         cap_ff      <= CNT_W'(CAP_RST);
         push_ff     <= '0;
         pop_ff      <= '0;
         closed_ff   <= 1'b0;
         error_ff    <= 1'b0;
         accepted_ff <= 1'b0;
      end else if (cmd.cfg_write) begin
         cap_ff  <= cap_in;
         head_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.exec) begin
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         push_ff     <= push_in;
         pop_ff      <= pop_in;
         closed_ff   <= closed_in;
         error_ff    <= error_in;
         accepted_ff <= accepted_in;
      end
   end

   brf_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(tail_pos[AW-1:0]),
      .wr_data(byte_ff),
      .rd_en  (cmd.read),
      .rd_addr(head_ff),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_accepted_ff   <= accepted_ff;
         out_head_valid_ff <= (fill_ff != '0);
         out_head_byte_ff  <= (fill_ff != '0) ? ram_rdata : '0;
         out_buffered_ff   <= fill_ff;
         out_free_ff       <= cap_ff - fill_ff;
         out_pushed_ff     <= push_ff;
         out_popped_ff     <= pop_ff;
         out_closed_ff     <= closed_ff;
         out_error_ff      <= error_ff;
         out_finished_ff   <= closed_ff && (fill_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.out_blocked = rsp_valid_ff && rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = out_accepted_ff;
   assign rsp_head_byte    = out_head_byte_ff;
   assign rsp_head_valid   = out_head_valid_ff;
   assign rsp_buffered     = out_buffered_ff;
   assign rsp_free_space   = out_free_ff;
   assign rsp_pushed_total = out_pushed_ff;
   assign rsp_popped_total = out_popped_ff;
   assign rsp_closed_flag  = out_closed_ff;
   assign rsp_error_flag   = out_error_ff;
   assign rsp_finished     = out_finished_ff;

endmodule

`default_nettype wire

[hw/rtl/byte_ring_fifo_with_close.sv]
// Top level of the byte ring FIFO with close and error marks.
// After its request is accepted, a response goes through state update with the
// byte store write, head read from the store port, and response load.
// The controller accepts the next request only after load, held there while the output stalls.
// Synchronous active-high reset clears pointers, totals and marks and sets capacity to 4096
// (or DEPTH if smaller); the byte store is not cleared and needs no clearing pass.
`default_nettype none

module byte_ring_fifo_with_close
   import brf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_command,
   input  wire logic [BYTE_W-1:0]  req_byte_in,
   input  wire logic [CNT_W-1:0]   req_pop_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_accepted,
   output logic      [BYTE_W-1:0]  rsp_head_byte,
   output logic                    rsp_head_valid,
   output logic      [CNT_W-1:0]   rsp_buffered,
   output logic      [CNT_W-1:0]   rsp_free_space,
   output logic      [TOTAL_W-1:0] rsp_pushed_total,
   output logic      [TOTAL_W-1:0] rsp_popped_total,
   output logic                    rsp_closed_flag,
   output logic                    rsp_error_flag,
   output logic                    rsp_finished,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CNT_W-1:0]   csr_capacity
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   brf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   brf_datapath #(
      .DEPTH(DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_command),
      .req_byte_in     (req_byte_in),
      .req_pop_count   (req_pop_count),
      .csr_capacity    (csr_capacity),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_head_byte   (rsp_head_byte),
      .rsp_head_valid  (rsp_head_valid),
      .rsp_buffered    (rsp_buffered),
      .rsp_free_space  (rsp_free_space),
      .rsp_pushed_total(rsp_pushed_total),
      .rsp_popped_total(rsp_popped_total),
      .rsp_closed_flag (rsp_closed_flag),
      .rsp_error_flag  (rsp_error_flag),
      .rsp_finished    (rsp_finished)
   );

endmodule

`default_nettype wire

[hw/rtl/brf_checker.sv]
// Port-level checker for the byte ring FIFO and its bind to the top level.
`default_nettype none

module brf_checker
   import brf_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic             rsp_accepted,
   input wire logic             rsp_head_valid,
   input wire logic [CNT_W-1:0] rsp_buffered,
   input wire logic             rsp_closed_flag,
   input wire logic             rsp_finished
);

   // A request is worked on alone, so the channel stalls right after acceptance.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another was in progress");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_head_valid == (rsp_buffered != '0)))
      else $error("head valid disagrees with buffered count");

   a_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_finished == (rsp_closed_flag && (rsp_buffered == '0))))
      else $error("finished flag disagrees with closed flag and buffered count");

   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> rsp_head_valid)
      else $error("stored byte but nothing is buffered");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_buffered)))
      else $error("stalled response changed");

endmodule

bind byte_ring_fifo_with_close brf_checker u_brf_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the byte ring FIFO: a directed table, random traffic with stalls.
module tb_top;
   import brf_pkg::*;

   localparam int RUN_LIMIT   = 400000;
   localparam int HOLD_CYCLES = 120;
   localparam int OPEN_ROWS   = 28;
   localparam int STEP_ROWS   = 38;

   typedef struct packed {
      logic                 accepted;
      logic [BYTE_W-1:0]    head_byte;
      logic                 head_valid;
      logic [CNT_W-1:0]     buffered;
      logic [CNT_W-1:0]     free_space;
      logic [TOTAL_W-1:0]   pushed_total;
      logic [TOTAL_W-1:0]   popped_total;
      logic                 closed_flag;
      logic                 error_flag;
      logic                 finished;
   } fifo_status_type;

   typedef struct packed {
      logic                 wr_cap;
      logic [CNT_W-1:0]     cap_val;
      logic [1:0]           cmd;
      logic [BYTE_W-1:0]    data;
      logic [CNT_W-1:0]     count;
      logic                 typed;
      logic                 t_acc;
      logic                 t_hv;
      logic [BYTE_W-1:0]    t_head;
      logic [CNT_W-1:0]     t_buf;
      logic [CNT_W-1:0]     t_free;
   } step_row_type;

   // The sticky marks can only be cleared by reset, so their rows come at the end of the table.
   localparam step_row_type STEPS [STEP_ROWS] = '{
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd0,    1'b1, 1'b0, 1'b0, 8'h00, 13'd0, 13'd4096},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd4096, 1'b1, 1'b0, 1'b0, 8'h00, 13'd0, 13'd4096},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h00, 13'd0,    1'b1, 1'b1, 1'b1, 8'h00, 13'd1, 13'd4095},
      '{1'b0, 13'd0,    CMD_PUSH,  8'hFF, 13'd0,    1'b1, 1'b1, 1'b1, 8'h00, 13'd2, 13'd4094},
      '{1'b0, 13'd0,    CMD_PUSH,  8'hA5, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd1,    1'b1, 1'b0, 1'b1, 8'hFF, 13'd2, 13'd4094},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd4096, 1'b1, 1'b0, 1'b0, 8'h00, 13'd0, 13'd4096},
      '{1'b1, 13'd0,    CMD_POP,   8'h00, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h11, 13'd0,    1'b1, 1'b1, 1'b1, 8'h11, 13'd1, 13'd0},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h22, 13'd0,    1'b1, 1'b0, 1'b1, 8'h11, 13'd1, 13'd0},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd1,    1'b1, 1'b0, 1'b0, 8'h00, 13'd0, 13'd1},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h33, 13'd0,    1'b1, 1'b1, 1'b1, 8'h33, 13'd1, 13'd0},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd2,    1'b1, 1'b0, 1'b0, 8'h00, 13'd0, 13'd1},
      '{1'b1, 13'd3,    CMD_POP,   8'h00, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h01, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h02, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h03, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h04, 13'd0,    1'b1, 1'b0, 1'b1, 8'h01, 13'd3, 13'd0},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd2,    1'b1, 1'b0, 1'b1, 8'h03, 13'd1, 13'd2},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h05, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h06, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd1,    1'b1, 1'b0, 1'b1, 8'h05, 13'd2, 13'd1},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h7F, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b1, 13'd8191, CMD_POP,   8'h00, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd0,    1'b1, 1'b0, 1'b0, 8'h00, 13'd0, 13'd4096},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h80, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b1, 13'd4097, CMD_POP,   8'h00, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd0,    1'b1, 1'b0, 1'b0, 8'h00, 13'd0, 13'd4096},
      '{1'b1, 13'd4,    CMD_POP,   8'h00, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_PUSH,  8'hC3, 13'd0,    1'b1, 1'b1, 1'b1, 8'hC3, 13'd1, 13'd3},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h3C, 13'd0,    1'b1, 1'b1, 1'b1, 8'hC3, 13'd2, 13'd2},
      '{1'b0, 13'd0,    CMD_CLOSE, 8'h00, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h99, 13'd0,    1'b1, 1'b0, 1'b1, 8'hC3, 13'd2, 13'd2},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd1,    1'b1, 1'b0, 1'b1, 8'h3C, 13'd1, 13'd3},
      '{1'b0, 13'd0,    CMD_ERROR, 8'h00, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0},
      '{1'b0, 13'd0,    CMD_PUSH,  8'h66, 13'd0,    1'b1, 1'b0, 1'b1, 8'h3C, 13'd1, 13'd3},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd4096, 1'b1, 1'b0, 1'b0, 8'h00, 13'd0, 13'd4},
      '{1'b0, 13'd0,    CMD_POP,   8'h00, 13'd0,    1'b0, 1'b0, 1'b0, 8'h00, 13'd0, 13'd0}
   };

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_command    = CMD_POP;
   logic [BYTE_W-1:0]    req_byte_in    = '0;
   logic [CNT_W-1:0]     req_pop_count  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic                 rsp_accepted;
   logic [BYTE_W-1:0]    rsp_head_byte;
   logic                 rsp_head_valid;
   logic [CNT_W-1:0]     rsp_buffered;
   logic [CNT_W-1:0]     rsp_free_space;
   logic [TOTAL_W-1:0]   rsp_pushed_total;
   logic [TOTAL_W-1:0]   rsp_popped_total;
   logic                 rsp_closed_flag;
   logic                 rsp_error_flag;
   logic                 rsp_finished;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CNT_W-1:0]     csr_capacity   = '0;

   // Predicted state of the block.
   logic [BYTE_W-1:0]    ring_copy [DEPTH_DEFAULT];
   int                   rd_ptr         = 0;
   int                   fill           = 0;
   int                   cap_eff        = CAP_RESET;
   logic [TOTAL_W-1:0]   n_pushed       = '0;
   logic [TOTAL_W-1:0]   n_popped       = '0;
   logic                 mark_closed    = 1'b0;
   logic                 mark_error     = 1'b0;

   fifo_status_type      status_q [$];
   fifo_status_type      rsp_want;
   int                   req_taken      = 0;
   int                   resp_seen      = 0;
   int                   mismatch_count = 0;
   int                   cycle_count    = 0;
   int                   send_idle_pct  = 0;
   int                   stall_pct      = 0;
   int                   hold_reqs      = 0;
   int                   hold_seen      = 0;
   int                   hold_left      = 0;
   int                   stat_cfg       = 0;
   int                   stat_full_drops = 0;
   int                   stat_mark_drops = 0;
   int                   stat_wraps     = 0;

   byte_ring_fifo_with_close i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_byte_in      (req_byte_in),
      .req_pop_count    (req_pop_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_head_byte    (rsp_head_byte),
      .rsp_head_valid   (rsp_head_valid),
      .rsp_buffered     (rsp_buffered),
      .rsp_free_space   (rsp_free_space),
      .rsp_pushed_total (rsp_pushed_total),
      .rsp_popped_total (rsp_popped_total),
      .rsp_closed_flag  (rsp_closed_flag),
      .rsp_error_flag   (rsp_error_flag),
      .rsp_finished     (rsp_finished),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_capacity     (csr_capacity)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, req_taken - resp_seen);
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_reqs != hold_seen) begin
         hold_seen <= hold_reqs;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 25) begin
         $display("Mismatch at response %0d: %s is 0x%0h, expected 0x%0h",
                  resp_seen, field, got, want);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (status_q.size() == 0) begin
            report_mismatch("response with no request waiting", 64'd1, 64'd0);
         end else begin
            rsp_want = status_q.pop_front();
            if (rsp_accepted !== rsp_want.accepted)
               report_mismatch("accepted", rsp_accepted, rsp_want.accepted);
            if (rsp_head_byte !== rsp_want.head_byte)
               report_mismatch("head_byte", rsp_head_byte, rsp_want.head_byte);
            if (rsp_head_valid !== rsp_want.head_valid)
               report_mismatch("head_valid", rsp_head_valid, rsp_want.head_valid);
            if (rsp_buffered !== rsp_want.buffered)
               report_mismatch("buffered", rsp_buffered, rsp_want.buffered);
            if (rsp_free_space !== rsp_want.free_space)
               report_mismatch("free_space", rsp_free_space, rsp_want.free_space);
            if (rsp_pushed_total !== rsp_want.pushed_total)
               report_mismatch("pushed_total", rsp_pushed_total, rsp_want.pushed_total);
            if (rsp_popped_total !== rsp_want.popped_total)
               report_mismatch("popped_total", rsp_popped_total, rsp_want.popped_total);
            if (rsp_closed_flag !== rsp_want.closed_flag)
               report_mismatch("closed_flag", rsp_closed_flag, rsp_want.closed_flag);
            if (rsp_error_flag !== rsp_want.error_flag)
               report_mismatch("error_flag", rsp_error_flag, rsp_want.error_flag);
            if (rsp_finished !== rsp_want.finished)
               report_mismatch("finished", rsp_finished, rsp_want.finished);
         end
         resp_seen <= resp_seen + 1;
      end
   end

   function automatic fifo_status_type fifo_apply(input logic [1:0] cmd,
                                                  input logic [BYTE_W-1:0] b,
                                                  input logic [CNT_W-1:0] cnt);
      fifo_status_type s;
      int              tail;
      int              take;
      s.accepted = 1'b0;
      case (cmd)
         CMD_PUSH: begin
            if (!mark_closed && !mark_error && fill < cap_eff) begin
               tail = rd_ptr + fill;
               if (tail >= cap_eff) tail -= cap_eff;
               ring_copy[tail] = b;
               fill++;
               n_pushed++;
               s.accepted = 1'b1;
            end else if (mark_closed || mark_error) begin
               stat_mark_drops++;
            end else begin
               stat_full_drops++;
            end
         end
         CMD_POP: begin
            take = (int'(cnt) < fill) ? int'(cnt) : fill;
            rd_ptr += take;
            if (take > 0 && rd_ptr >= cap_eff) begin
               rd_ptr -= cap_eff;
               stat_wraps++;
            end
            fill -= take;
            n_popped += take;
         end
         CMD_CLOSE: mark_closed = 1'b1;
         default:   mark_error = 1'b1;
      endcase
      s.head_valid   = (fill > 0);
      s.head_byte    = (fill > 0) ? ring_copy[rd_ptr] : '0;
      s.buffered     = fill[CNT_W-1:0];
      s.free_space   = CNT_W'(cap_eff - fill);
      s.pushed_total = n_pushed;
      s.popped_total = n_popped;
      s.closed_flag  = mark_closed;
      s.error_flag   = mark_error;
      s.finished     = mark_closed && (fill == 0);
      return s;
   endfunction

   function automatic logic [CNT_W-1:0] pick_pop_count();
      int unsigned k;
      k = $urandom_range(9);
      if (k == 0) return '0;
      if (k == 1) return CNT_W'(4096);
      if (k <= 3) return CNT_W'($urandom_range(4096));
      return CNT_W'($urandom_range(1, (cap_eff < 4096) ? cap_eff + 1 : 4096));
   endfunction

   task automatic send_req(input logic [1:0] cmd, input logic [BYTE_W-1:0] b,
                           input logic [CNT_W-1:0] cnt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_byte_in   <= b;
      req_pop_count <= cnt;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      status_q.push_back(fifo_apply(cmd, b, cnt));
      req_taken++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (resp_seen != req_taken);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] v);
      wait_drained();
      csr_valid    <= 1'b1;
      csr_capacity <= v;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      cap_eff = (v == 0) ? 1 : ((int'(v) > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(v));
      rd_ptr  = 0;
      fill    = 0;
      stat_cfg++;
   endtask

   task automatic walk_steps(input int first, input int last, input bit swap_marks);
      step_row_type    r;
      fifo_status_type e;
      logic [1:0]      c;
      for (int i = first; i <= last; i++) begin
         r = STEPS[i];
         if (r.wr_cap) begin
            write_capacity(r.cap_val);
         end else begin
            c = (swap_marks && r.cmd inside {CMD_CLOSE, CMD_ERROR}) ? (r.cmd ^ 2'b01) : r.cmd;
            send_req(c, r.data, r.count);
            if (r.typed) begin
               e = status_q.pop_back();
               e.accepted   = r.t_acc;
               e.head_valid = r.t_hv;
               e.head_byte  = r.t_head;
               e.buffered   = r.t_buf;
               e.free_space = r.t_free;
               status_q.push_back(e);
            end
         end
      end
   endtask

   initial begin
      int          phase_items;
      int          seg_len;
      int unsigned pick;
      logic [CNT_W-1:0] cap_val;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      walk_steps(0, OPEN_ROWS - 1, 1'b0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 38 : ((phase == 1) ? 72 : 0);
         stall_pct    <= (phase == 0) ? 72 : ((phase == 1) ? 38 : 0);
         phase_items   = 0;
         while (phase_items < 205) begin
            pick = $urandom_range(99);
            if (pick < 55)      cap_val = CNT_W'($urandom_range(1, 8));
            else if (pick < 85) cap_val = CNT_W'($urandom_range(9, 64));
            else if (pick < 95) cap_val = CNT_W'($urandom_range(65, 4096));
            else if (pick < 97) cap_val = '0;
            else                cap_val = CNT_W'($urandom_range(4096, 8191));
            write_capacity(cap_val);
            // The receiver holds off while requests keep coming, so the block backs up.
            if (phase_items == 0 && phase != 1) hold_reqs <= hold_reqs + 1;
            seg_len = $urandom_range(20, 60);
            for (int k = 0; k < seg_len; k++) begin
               if (phase == 1 && phase_items == 60) wait_drained();
               if ($urandom_range(99) < 55) begin
                  send_req(CMD_PUSH, BYTE_W'($urandom_range(255)), CNT_W'($urandom_range(8191)));
               end else begin
                  send_req(CMD_POP, BYTE_W'($urandom_range(255)), pick_pop_count());
               end
               phase_items++;
            end
         end
      end

      send_idle_pct = 20;
      stall_pct    <= 30;
      walk_steps(OPEN_ROWS, STEP_ROWS - 1, 1'($urandom_range(1)));
      for (int k = 0; k < 40; k++) begin
         send_req(2'($urandom_range(3)), BYTE_W'($urandom_range(255)), pick_pop_count());
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (status_q.size() != 0) begin
         report_mismatch("responses never returned", status_q.size(), 64'd0);
      end

      $display("Covered %0d requests and %0d responses across %0d capacity settings.",
               req_taken, resp_seen, stat_cfg);
      $display("Stored %0d bytes; %0d dropped when full, %0d after a mark; %0d head wraps.",
               n_pushed, stat_full_drops, stat_mark_drops, stat_wraps);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[byte_ring_fifo_with_close.f]
hw/rtl/brf_pkg.sv
hw/rtl/brf_ram.sv
hw/rtl/brf_ctrl.sv
hw/rtl/brf_datapath.sv
hw/rtl/byte_ring_fifo_with_close.sv
hw/rtl/brf_checker.sv
tb/sv/tb_top.sv
